// ----- hdl/rfa_pkg.sv -----
package rfa_pkg;

    localparam int MAX_FIELDS = 16;
    localparam int TBL_AW     = 4;   // table address width
    localparam int CNT_W      = 5;   // field counter width, holds MAX_FIELDS
    localparam int DIV_STEPS  = 63;  // dividend bits

    localparam logic REQ_LOAD     = 1'b0;
    localparam logic REQ_PARTICLE = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic [3:0]         field_index;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [30:0]        field_radius;
        logic signed [31:0] field_strength;
        logic signed [31:0] force_in_x;
        logic signed [31:0] force_in_y;
        logic signed [31:0] force_in_z;
        logic               last_particle;
    } t_item;

    typedef struct packed {
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        logic               batch_done;
    } t_result;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FETCH,
        S_CHECK,
        S_SQ,
        S_SQCHK,
        S_SQRT,
        S_MAG,
        S_MAGDIV,
        S_COMP,
        S_COMPDIV,
        S_NEXT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic        start;
        logic [62:0] num;
        logic [31:0] den;
    } t_div_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] quo;
    } t_div_rsp;

endpackage

// ----- hdl/rfa_if.sv -----
interface rfa_in_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [3:0]         field_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [30:0]        field_radius;
    logic signed [31:0] field_strength;
    logic signed [31:0] force_in_x;
    logic signed [31:0] force_in_y;
    logic signed [31:0] force_in_z;
    logic               last_particle;

    modport source (output valid, req_type, field_index, pos_x, pos_y, pos_z, field_radius,
                    field_strength, force_in_x, force_in_y, force_in_z, last_particle,
                    input ready);
    modport sink (input valid, req_type, field_index, pos_x, pos_y, pos_z, field_radius,
                  field_strength, force_in_x, force_in_y, force_in_z, last_particle,
                  output ready);
endinterface

interface rfa_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic               batch_done;

    modport source (output valid, force_x, force_y, force_z, batch_done, input ready);
    modport sink (input valid, force_x, force_y, force_z, batch_done, output ready);
endinterface

interface rfa_cfg_if;
    logic       valid;
    logic       ready;
    logic [4:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ----- hdl/rfa_queue.sv -----
module rfa_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    rfa_in_if.sink         i_in,
    output logic           o_valid,
    output rfa_pkg::t_item o_item,
    input  logic           i_pop
);
    import rfa_pkg::*;

    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;
    t_item      in_item;

    assign i_in.ready = (r_cnt != 2'd2);
    assign push       = i_in.valid && i_in.ready;
    assign pop        = i_pop && (r_cnt != 2'd0);
    assign o_valid    = (r_cnt != 2'd0);
    assign o_item     = r_mem[r_rp];

    always_comb begin
        in_item.req_type       = i_in.req_type;
        in_item.field_index    = i_in.field_index;
        in_item.pos_x          = i_in.pos_x;
        in_item.pos_y          = i_in.pos_y;
        in_item.pos_z          = i_in.pos_z;
        in_item.field_radius   = i_in.field_radius;
        in_item.field_strength = i_in.field_strength;
        in_item.force_in_x     = i_in.force_in_x;
        in_item.force_in_y     = i_in.force_in_y;
        in_item.force_in_z     = i_in.force_in_z;
        in_item.last_particle  = i_in.last_particle;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= in_item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ----- hdl/rfa_div.sv -----
module rfa_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rfa_pkg::t_div_req i_req,
    output rfa_pkg::t_div_rsp o_rsp
);
    import rfa_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [62:0] r_num;
    logic [31:0] r_den;
    logic [32:0] r_rem;
    logic [31:0] r_q;
    logic [32:0] rem_sh;
    logic        fits;

    // restoring division, one quotient bit per cycle; quotient fits 32 bits
    assign rem_sh = {r_rem[31:0], r_num[62]};
    assign fits   = (rem_sh >= {1'b0, r_den});

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_q;

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.num;
            r_den <= i_req.den;
            r_rem <= '0;
            r_q   <= '0;
            r_cnt <= 6'(DIV_STEPS - 1);
        end else if (r_busy) begin
            r_num <= {r_num[61:0], 1'b0};
            r_rem <= fits ? (rem_sh - {1'b0, r_den}) : rem_sh;
            r_q   <= {r_q[30:0], fits};
            r_cnt <= r_cnt - 6'd1;
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == 6'd0);
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == 6'd0)) begin
                r_busy <= 1'b0;
            end
        end
    end

endmodule

// ----- hdl/rfa_engine.sv -----
module rfa_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [4:0]         i_count,
    input  logic               i_valid,
    input  rfa_pkg::t_item     i_item,
    output logic               o_pop,
    output rfa_pkg::t_div_req  o_div,
    input  rfa_pkg::t_div_rsp  i_div,
    rfa_out_if.source          o_out
);
    import rfa_pkg::*;

    t_state r_state, n_state;

    logic signed [31:0] r_cx  [MAX_FIELDS];
    logic signed [31:0] r_cy  [MAX_FIELDS];
    logic signed [31:0] r_cz  [MAX_FIELDS];
    logic [30:0]        r_rad [MAX_FIELDS];
    logic signed [31:0] r_st  [MAX_FIELDS];

    logic [CNT_W-1:0]   r_j;
    logic [1:0]         r_k;
    logic signed [31:0] r_px, r_py, r_pz;
    logic signed [31:0] r_acc [3];
    logic               r_last;
    logic signed [32:0] r_dv  [3];
    logic [30:0]        r_adv [3];
    logic [30:0]        r_r;
    logic signed [31:0] r_str;
    logic [63:0]        r_s;
    logic [33:0]        r_rem;
    logic [31:0]        r_root;
    logic [4:0]         r_sc;
    logic [62:0]        r_prod;
    logic [31:0]        r_mag;
    logic               r_mag_neg;
    logic               r_go;
    t_result            r_res;
    logic               r_ov;

    logic [32:0]        abs_dv [3];
    logic               far;
    logic [61:0]        rr;
    logic [35:0]        rem_sh;
    logic [35:0]        trial;
    logic [31:0]        str_abs;
    logic [30:0]        d;
    logic               cneg;
    logic signed [33:0] csum;
    logic signed [31:0] cclamp;
    logic               out_free;
    logic [TBL_AW-1:0]  ja;

    assign ja       = r_j[TBL_AW-1:0];
    assign out_free = !r_ov || o_out.ready;
    assign d        = r_root[30:0];
    assign str_abs  = r_str[31] ? 32'(-r_str) : 32'(r_str);
    assign rr       = 62'(r_r) * 62'(r_r);
    assign rem_sh   = {r_rem, r_s[63:62]};
    assign trial    = {2'b00, r_root, 2'b01};

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            abs_dv[k] = r_dv[k][32] ? 33'(-r_dv[k]) : 33'(r_dv[k]);
        end
        far = (abs_dv[0] >= {2'b00, r_r}) || (abs_dv[1] >= {2'b00, r_r})
            || (abs_dv[2] >= {2'b00, r_r});
    end

    // saturating add of the signed component quotient
    always_comb begin
        cneg = r_dv[r_k][32] ^ r_mag_neg;
        csum = 34'(r_acc[r_k]) + (cneg ? -$signed({2'b00, i_div.quo})
                                       : $signed({2'b00, i_div.quo}));
        if (csum > 34'sh0_7FFF_FFFF) begin
            cclamp = 32'sh7FFF_FFFF;
        end else if (csum < -34'sh0_8000_0000) begin
            cclamp = -32'sh8000_0000;
        end else begin
            cclamp = csum[31:0];
        end
    end

    always_comb begin
        n_state   = r_state;
        o_pop     = 1'b0;
        o_div.start = 1'b0;
        o_div.num = r_prod;
        o_div.den = (r_state == S_MAGDIV) ? {1'b0, r_r} : {1'b0, d};
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_pop = 1'b1;
                    if (i_item.req_type == REQ_PARTICLE) begin
                        n_state = S_FETCH;
                    end
                end
            end
            S_FETCH:   n_state = (r_j >= i_count) ? S_OUT : S_CHECK;
            S_CHECK:   n_state = ((r_r == '0) || far) ? S_NEXT : S_SQ;
            S_SQ:      n_state = (r_k == 2'd2) ? S_SQCHK : S_SQ;
            S_SQCHK:   n_state = ((r_s == '0) || (r_s >= 64'(rr))) ? S_NEXT : S_SQRT;
            S_SQRT:    n_state = (r_sc == 5'd0) ? S_MAG : S_SQRT;
            S_MAG:     n_state = S_MAGDIV;
            S_MAGDIV: begin
                o_div.start = !r_go;
                if (i_div.done) begin
                    n_state = S_COMP;
                end
            end
            S_COMP:    n_state = S_COMPDIV;
            S_COMPDIV: begin
                o_div.start = !r_go;
                if (i_div.done) begin
                    n_state = (r_k == 2'd2) ? S_NEXT : S_COMP;
                end
            end
            S_NEXT:    n_state = S_FETCH;
            S_OUT:     n_state = out_free ? S_IDLE : S_OUT;
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && i_item.req_type == REQ_LOAD) begin
                    r_cx[i_item.field_index[TBL_AW-1:0]]  <= i_item.pos_x;
                    r_cy[i_item.field_index[TBL_AW-1:0]]  <= i_item.pos_y;
                    r_cz[i_item.field_index[TBL_AW-1:0]]  <= i_item.pos_z;
                    r_rad[i_item.field_index[TBL_AW-1:0]] <= i_item.field_radius;
                    r_st[i_item.field_index[TBL_AW-1:0]]  <= i_item.field_strength;
                end
                r_px     <= i_item.pos_x;
                r_py     <= i_item.pos_y;
                r_pz     <= i_item.pos_z;
                r_acc[0] <= i_item.force_in_x;
                r_acc[1] <= i_item.force_in_y;
                r_acc[2] <= i_item.force_in_z;
                r_last   <= i_item.last_particle;
                r_j      <= '0;
            end
            S_FETCH: begin
                r_dv[0] <= 33'(r_cx[ja]) - 33'(r_px);
                r_dv[1] <= 33'(r_cy[ja]) - 33'(r_py);
                r_dv[2] <= 33'(r_cz[ja]) - 33'(r_pz);
                r_r     <= r_rad[ja];
                r_str   <= r_st[ja];
            end
            S_CHECK: begin
                for (int k = 0; k < 3; k++) begin
                    r_adv[k] <= abs_dv[k][30:0];
                end
                r_s <= '0;
                r_k <= '0;
            end
            S_SQ: begin
                r_s <= r_s + 64'(62'(r_adv[r_k]) * 62'(r_adv[r_k]));
                r_k <= (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
            end
            S_SQCHK: begin
                r_rem  <= '0;
                r_root <= '0;
                r_sc   <= 5'd31;
            end
            S_SQRT: begin
                // one root bit per cycle from the top bit pair of r_s
                if (rem_sh >= trial) begin
                    r_rem  <= 34'(rem_sh - trial);
                    r_root <= {r_root[30:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh[33:0];
                    r_root <= {r_root[30:0], 1'b0};
                end
                r_s  <= {r_s[61:0], 2'b00};
                r_sc <= r_sc - 5'd1;
            end
            S_MAG: begin
                r_prod    <= 63'(str_abs) * 63'(r_r - d);
                r_mag_neg <= r_str[31];
                r_go      <= 1'b0;
            end
            S_MAGDIV: begin
                if (o_div.start) begin
                    r_go <= 1'b1;
                end
                if (i_div.done) begin
                    r_mag <= i_div.quo;
                    r_k   <= '0;
                end
            end
            S_COMP: begin
                r_prod <= 63'(r_adv[r_k]) * 63'(r_mag);
                r_go   <= 1'b0;
            end
            S_COMPDIV: begin
                if (o_div.start) begin
                    r_go <= 1'b1;
                end
                if (i_div.done) begin
                    r_acc[r_k] <= cclamp;
                    r_k        <= r_k + 2'd1;
                end
            end
            S_NEXT: r_j <= r_j + 1'b1;
            S_OUT: begin
                if (out_free) begin
                    r_res.force_x    <= r_acc[0];
                    r_res.force_y    <= r_acc[1];
                    r_res.force_z    <= r_acc[2];
                    r_res.batch_done <= r_last;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.force_x    = r_res.force_x;
    assign o_out.force_y    = r_res.force_y;
    assign o_out.force_z    = r_res.force_z;
    assign o_out.batch_done = r_res.batch_done;

    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_div.start |-> !i_div.busy)
        else $error("divider started while busy");

    a_j_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_j <= CNT_W'(MAX_FIELDS)))
        else $error("field counter out of range");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(r_state == S_OUT))
        else $error("result raised outside output state");

endmodule

// ----- hdl/radial_force_field_accumulate.sv -----
// Radial attractor force accumulator, Q16.16. Load transactions write one of 16 field
// entries; particle transactions return the incoming force plus the saturated sum of
// each active field's pull. An input queue of two entries decouples intake from a
// sequential engine that handles one field at a time: a field that fails the per-axis
// distance test or the squared-distance test is skipped before the square root, while an
// active one takes 3 squares, a 32-step square root, then four divisions through one
// shared 63-step bit-serial divider. A particle passes the idle, fetch and output states
// around that work; a load is done in the idle state. field_count above 16 acts as 16.
module radial_force_field_accumulate (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rfa_in_if.sink     i_in,
    rfa_cfg_if.sink    i_cfg,
    rfa_out_if.source  o_out
);
    import rfa_pkg::*;

    logic [4:0] r_field_count;
    logic [4:0] count_eff;
    logic       q_valid;
    t_item      q_item;
    logic       q_pop;
    t_div_req   div_req;
    t_div_rsp   div_rsp;

    assign i_cfg.ready = 1'b1;
    assign count_eff   = (r_field_count > 5'(MAX_FIELDS)) ? 5'(MAX_FIELDS) : r_field_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_count <= '0;
        end else if (i_cfg.valid) begin
            r_field_count <= i_cfg.data;
        end
    end

    rfa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (q_pop)
    );

    rfa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    rfa_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_count (count_eff),
        .i_valid (q_valid),
        .i_item  (q_item),
        .o_pop   (q_pop),
        .o_div   (div_req),
        .i_div   (div_rsp),
        .o_out   (o_out)
    );

endmodule
